// ===== design/pcm_block_level_statistics_core_macros.svh =====
// Assertion helpers shared by the statistics core.
`ifndef PCM_BLOCK_LEVEL_STATISTICS_CORE_MACROS_SVH
`define PCM_BLOCK_LEVEL_STATISTICS_CORE_MACROS_SVH

// Check on every rising clk edge outside reset.
`define PBLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising clk edge, reset included.
`define PBLS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/pbls_pkg.sv =====
package pbls_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 13;

  localparam logic [CFG_W-1:0]    CFG_RESET = 13'd4096;
  localparam logic [SAMPLE_W-1:0] MIN_INIT  = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] MAX_INIT  = 16'h8000;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_LOAD
  } state_t;

endpackage

// ===== design/pcm_block_level_statistics_core.sv =====
// A sample that does not close its block is taken without a stall; samples stream at one per cycle in
// the accumulate state. The closing sample starts the restoring divider (one quotient bit per cycle
// over the sum width, 28 at MAX_BLOCK_LEN 4096); its done moves the core to the load state.
// Input is stalled from the closing sample until the result is loaded into the output register,
// and the load waits while a still-valid result is stalled; result_valid is registered from it.
// Synchronous reset: running values cleared, block_length back to 4096, no result pending.
`include "pcm_block_level_statistics_core_macros.svh"

module pcm_block_level_statistics_core #(
  parameter int MAX_BLOCK_LEN = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [pbls_pkg::SAMPLE_W-1:0] pcm_sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [pbls_pkg::SAMPLE_W-1:0] block_min,
  output logic signed [pbls_pkg::SAMPLE_W-1:0] block_max,
  output logic        [pbls_pkg::SAMPLE_W-1:0] block_peak_abs,
  output logic        [pbls_pkg::SAMPLE_W-1:0] block_mean_abs,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [pbls_pkg::CFG_W-1:0]    block_length
);

  localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 1);
  localparam int SUM_W = $clog2(32768 * MAX_BLOCK_LEN + 1);
  localparam int SW    = pbls_pkg::SAMPLE_W;

  pbls_pkg::state_t state, state_next;

  logic [pbls_pkg::CFG_W-1:0] len_reg;
  logic signed [SW-1:0]       running_min;
  logic signed [SW-1:0]       running_max;
  logic [SW-1:0]              running_peak;
  logic [SUM_W-1:0]           abs_total;
  logic [CNT_W-1:0]           samples_seen;

  logic                       accept;
  logic                       out_free;
  logic [SW-1:0]              mag;
  logic [SUM_W-1:0]           total_upd;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           eff_len;
  logic                       closing;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           quotient;
  logic                       load_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= pbls_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_reg <= block_length;
    end
  end

  // Zero means one; saturate at the top.
  always_comb begin
    if (len_reg == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(len_reg) > 32'(MAX_BLOCK_LEN)) begin
      eff_len = CNT_W'(MAX_BLOCK_LEN);
    end else begin
      eff_len = CNT_W'(len_reg);
    end
  end

  always_comb begin
    mag       = pcm_sample[SW-1] ? (~pcm_sample + 1'b1) : pcm_sample;
    total_upd = abs_total + SUM_W'(mag);
    count     = samples_seen + 1'b1;
    closing   = (count >= eff_len);
  end

  assign accept    = sample_valid && !sample_stall;
  assign out_free  = !result_valid || !result_stall;
  assign div_start = accept && closing;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pbls_pkg::ST_ACCUM: begin
        if (div_start) begin
          state_next = pbls_pkg::ST_DIV;
        end
      end
      pbls_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = pbls_pkg::ST_LOAD;
        end
      end
      pbls_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = pbls_pkg::ST_ACCUM;
        end
      end
      default: state_next = pbls_pkg::ST_ACCUM;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    sample_stall = 1'b1;
    load_result  = 1'b0;
    case (state)
      pbls_pkg::ST_ACCUM: sample_stall = 1'b0;
      pbls_pkg::ST_DIV:   sample_stall = 1'b1;
      pbls_pkg::ST_LOAD:  load_result  = out_free;
      default:            sample_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbls_pkg::ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Running values hold through the divide and clear when the result is loaded.
  always_ff @(posedge clk) begin
    if (rst || load_result) begin
      running_min  <= pbls_pkg::MIN_INIT;
      running_max  <= pbls_pkg::MAX_INIT;
      running_peak <= '0;
      abs_total    <= '0;
      samples_seen <= '0;
    end else if (accept) begin
      if (pcm_sample < running_min) begin
        running_min <= pcm_sample;
      end
      if (pcm_sample > running_max) begin
        running_max <= pcm_sample;
      end
      if (mag > running_peak) begin
        running_peak <= mag;
      end
      abs_total    <= total_upd;
      samples_seen <= count;
    end
  end

  pbls_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_upd),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      block_min      <= running_min;
      block_max      <= running_max;
      block_peak_abs <= running_peak;
      block_mean_abs <= quotient[SW-1:0];
    end
  end

  `PBLS_ASSERT(a_result_from_load, $rose(result_valid) |-> $past(state) == pbls_pkg::ST_LOAD, "result appeared without a load")
  `PBLS_ASSERT(a_done_in_div, div_done |-> state == pbls_pkg::ST_DIV, "divider finished outside the divide state")
  `PBLS_ASSERT(a_div_entry, (state == pbls_pkg::ST_DIV && $past(state) == pbls_pkg::ST_ACCUM) |-> $past(accept), "divide entered without a closing transfer")
  `PBLS_ASSERT_ALWAYS(a_count_range, rst || (32'(samples_seen) <= 32'(MAX_BLOCK_LEN)), "sample count beyond block limit")

endmodule

// ===== design/pbls_div.sv =====
module pbls_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] steps_left;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  dvs;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;

  // One restoring step: shift in the next dividend bit, try the subtract.
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      done       <= 1'b0;
    end else if (start) begin
      steps_left <= STEP_W'(DVD_W);
      done       <= 1'b0;
    end else if (steps_left != '0) begin
      steps_left <= steps_left - 1'b1;
      done       <= (steps_left == STEP_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (steps_left != '0) begin
      if (diff[DVS_W+1]) begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end else begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end
    end
  end

  assign quotient = quo;

endmodule
